// File: hw/rtl/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and constants of the shelf rectangle packer: transfer payloads,
// status codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package srp_pkg;

    localparam int MAX_PAGES_DEF     = 16;
    localparam int MAX_PAGE_SIDE_DEF = 1024;
    localparam int BORDER_DEF        = 1;

    localparam int RECT_W     = 10;
    localparam int PAD_W      = 11;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int PAGE_IDX_W = 4;
    localparam int POS_W      = 10;

    localparam logic [CFG_W-1:0] CFG_SIDE_RESET = CFG_W'(1024);

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_PLACED   = 2'd0,
        ST_OVERSIZE = 2'd1,
        ST_NO_PAGE  = 2'd2
    } t_status;

    typedef struct packed {
        logic [RECT_W-1:0] rect_width;
        logic [RECT_W-1:0] rect_height;
    } t_rect;

    typedef struct packed {
        t_status               status;
        logic [PAGE_IDX_W-1:0] page_index;
        logic [POS_W-1:0]      pos_x;
        logic [POS_W-1:0]      pos_y;
        logic                  opened_page;
    } t_place;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
    } t_cfg_wr;

endpackage

`default_nettype wire

// File: hw/rtl/srp_stream_if.sv
// ----------------------------------------------------------------------------
// srp_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface srp_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/shelf_rect_packer_unit.sv
// ----------------------------------------------------------------------------
// shelf_rect_packer_unit
// First-fit shelf packer of bordered rectangles over a set of atlas pages.
//
//   channel  dir  payload                                      ready
//   i_rect   in   rect_width, rect_height                      idle only
//   o_place  out  status, page_index, pos_x, pos_y, opened_page
//   i_cfg    in   index, value (page_width, page_height)       always
//
// An item goes through set-up and an oversize check, then per page tried a memory
// read, width test, optional row wrap and height test, and a new-page step when no
// open page fits; the page scan runs through one shared adder/comparator.
// After reset one empty page exists; no clearing pass.
// A finished result is held in the output register; the next item is taken
// meanwhile and only its final step waits for that register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module shelf_rect_packer_unit
    import srp_pkg::*;
#(
    parameter int MAX_PAGES     = MAX_PAGES_DEF,
    parameter int MAX_PAGE_SIDE = MAX_PAGE_SIDE_DEF,
    parameter int BORDER        = BORDER_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    srp_stream_if.sink   i_rect,
    srp_stream_if.source o_place,
    srp_stream_if.sink   i_cfg
);

    localparam int SW = $clog2(MAX_PAGE_SIDE + 1);
    localparam int DW = ((SW > PAD_W) ? SW : PAD_W) + 1;
    localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int NW = $clog2(MAX_PAGES + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_READ  = 7'b0000100,
        S_FITX  = 7'b0001000,
        S_WRAP  = 7'b0010000,
        S_FITY  = 7'b0100000,
        S_NEWPG = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_page_width, r_page_height;
    logic [NW-1:0]    r_pages, n_pages;
    logic [NW-1:0]    r_n, n_n;
    logic [NW-1:0]    r_p, n_p;
    logic [DW-1:0]    r_pw, n_pw, r_ph, n_ph;
    logic [DW-1:0]    r_w, n_w, r_h, n_h;
    logic [DW-1:0]    r_cx, n_cx, r_cy, n_cy, r_tall, n_tall, r_nx, n_nx;
    logic             r_out_valid, n_out_valid;
    t_place           r_out, n_out;

    logic [DW-1:0]    alu_a, alu_b, alu_lim, alu_sum;
    logic             alu_gt;
    logic [DW-1:0]    w_clamp, h_clamp;
    logic             can_load;
    logic [NW-1:0]    p_next;
    logic [DW-1:0]    tall_max;

    logic             rd_en, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [SW-1:0]    wr_cx, wr_cy, wr_tall;
    logic [SW-1:0]    rd_cx, rd_cy, rd_tall;

    srp_page_store #(
        .DEPTH (MAX_PAGES),
        .AW    (AW),
        .SW    (SW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_cx   (wr_cx),
        .i_wr_cy   (wr_cy),
        .i_wr_tall (wr_tall),
        .o_rd_cx   (rd_cx),
        .o_rd_cy   (rd_cy),
        .o_rd_tall (rd_tall)
    );

    // shared adder and limit compare
    assign alu_sum = alu_a + alu_b;
    assign alu_gt  = alu_sum > alu_lim;

    always_comb begin
        w_clamp = DW'(r_page_width);
        h_clamp = DW'(r_page_height);
        if (w_clamp > DW'(MAX_PAGE_SIDE)) begin
            w_clamp = DW'(MAX_PAGE_SIDE);
        end
        if (h_clamp > DW'(MAX_PAGE_SIDE)) begin
            h_clamp = DW'(MAX_PAGE_SIDE);
        end
    end

    assign can_load  = !r_out_valid || o_place.ready;
    assign p_next    = r_p + NW'(1);
    assign tall_max  = (r_tall > r_ph) ? r_tall : r_ph;

    assign i_rect.ready  = (r_state == S_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_place.valid = r_out_valid;
    assign o_place.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_pages     = r_pages;
        n_n         = r_n;
        n_p         = r_p;
        n_pw        = r_pw;
        n_ph        = r_ph;
        n_w         = r_w;
        n_h         = r_h;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_tall      = r_tall;
        n_nx        = r_nx;
        n_out_valid = r_out_valid && !o_place.ready;
        n_out       = r_out;
        alu_a       = '0;
        alu_b       = '0;
        alu_lim     = '0;
        rd_en       = 1'b0;
        rd_addr     = r_p[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_p[AW-1:0];
        wr_cx       = r_nx[SW-1:0];
        wr_cy       = r_cy[SW-1:0];
        wr_tall     = tall_max[SW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_rect.valid) begin
                    n_pw    = DW'(i_rect.data.rect_width) + DW'(2 * BORDER);
                    n_ph    = DW'(i_rect.data.rect_height) + DW'(2 * BORDER);
                    n_w     = w_clamp;
                    n_h     = h_clamp;
                    n_n     = r_pages;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((r_pw > r_w) || (r_ph > r_h)) begin
                    if (can_load) begin
                        n_out_valid = 1'b1;
                        n_out       = '{status: ST_OVERSIZE, default: '0};
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_p     = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_FITX;
            end
            S_FITX: begin
                alu_a   = DW'(rd_cx);
                alu_b   = r_pw;
                alu_lim = r_w;
                n_cy    = DW'(rd_cy);
                n_tall  = DW'(rd_tall);
                if (alu_gt) begin
                    n_cx    = '0;
                    n_nx    = r_pw;
                    n_state = S_WRAP;
                end else begin
                    n_cx    = DW'(rd_cx);
                    n_nx    = alu_sum;
                    n_state = S_FITY;
                end
            end
            S_WRAP: begin
                alu_a   = r_cy;
                alu_b   = r_tall;
                n_cy    = alu_sum;
                n_tall  = '0;
                n_state = S_FITY;
            end
            S_FITY: begin
                alu_a   = r_cy;
                alu_b   = r_ph;
                alu_lim = r_h;
                if (!alu_gt) begin
                    if (can_load) begin
                        wr_en       = 1'b1;
                        n_out_valid = 1'b1;
                        n_out       = '{status:      ST_PLACED,
                                        page_index:  PAGE_IDX_W'(r_p),
                                        pos_x:       POS_W'(r_cx + DW'(BORDER)),
                                        pos_y:       POS_W'(r_cy + DW'(BORDER)),
                                        opened_page: 1'b0};
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_p     = p_next;
                    n_state = (p_next == r_n) ? S_NEWPG : S_READ;
                end
            end
            S_NEWPG: begin
                wr_addr = r_n[AW-1:0];
                wr_cx   = r_pw[SW-1:0];
                wr_cy   = '0;
                wr_tall = r_ph[SW-1:0];
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_n >= NW'(MAX_PAGES)) begin
                        n_out = '{status: ST_NO_PAGE, default: '0};
                    end else begin
                        wr_en   = 1'b1;
                        n_pages = r_n + NW'(1);
                        n_out   = '{status:      ST_PLACED,
                                    page_index:  PAGE_IDX_W'(r_n),
                                    pos_x:       POS_W'(BORDER),
                                    pos_y:       POS_W'(BORDER),
                                    opened_page: 1'b1};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pages       <= NW'(1);
            r_out_valid   <= 1'b0;
            r_page_width  <= CFG_SIDE_RESET;
            r_page_height <= CFG_SIDE_RESET;
        end else begin
            r_state     <= n_state;
            r_pages     <= n_pages;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    REG_PAGE_WIDTH:  r_page_width  <= i_cfg.data.value;
                    REG_PAGE_HEIGHT: r_page_height <= i_cfg.data.value;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_p    <= n_p;
        r_pw   <= n_pw;
        r_ph   <= n_ph;
        r_w    <= n_w;
        r_h    <= n_h;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_tall <= n_tall;
        r_nx   <= n_nx;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

// File: hw/rtl/srp_page_store.sv
// ----------------------------------------------------------------------------
// srp_page_store
// Per-page row state (cursor, row top, tallest item) in a memory with one read
// and one write port and registered read; page 0 reads as empty until first written.
// ----------------------------------------------------------------------------
`default_nettype none

module srp_page_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int SW    = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [SW-1:0] i_wr_cx,
    input  wire logic [SW-1:0] i_wr_cy,
    input  wire logic [SW-1:0] i_wr_tall,
    output logic      [SW-1:0] o_rd_cx,
    output logic      [SW-1:0] o_rd_cy,
    output logic      [SW-1:0] o_rd_tall
);

    logic [3*SW-1:0] r_mem [DEPTH];
    logic [3*SW-1:0] r_rd;
    logic            r_rd_blank;
    logic            r_p0_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_cx, i_wr_cy, i_wr_tall};
        end
        if (i_rd_en) begin
            r_rd       <= r_mem[i_rd_addr];
            r_rd_blank <= (i_rd_addr == '0) && !r_p0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
        end else if (i_wr_en && (i_wr_addr == '0)) begin
            r_p0_valid <= 1'b1;
        end
    end

    assign o_rd_cx   = r_rd_blank ? '0 : r_rd[3*SW-1:2*SW];
    assign o_rd_cy   = r_rd_blank ? '0 : r_rd[2*SW-1:SW];
    assign o_rd_tall = r_rd_blank ? '0 : r_rd[SW-1:0];

endmodule

`default_nettype wire

// File: dv/tb_shelf_rect_packer_unit.sv
// ----------------------------------------------------------------------------
// tb_shelf_rect_packer_unit
// Self-checking bench for the shelf rectangle packer. A short stimulus table
// covers reset state, oversize rectangles, page opening and running out of
// pages. Random rectangles then run under a series of page sizes and idling
// patterns. Every placement is compared field by field against the table entry
// or a first-fit shelf packer kept alongside the block.
// ----------------------------------------------------------------------------
module tb_shelf_rect_packer_unit;
    import srp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int PHASES = 8;

    typedef enum {ROW_KNOWN, ROW_PREDICT, ROW_RESIZE} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_rect     rect;
        int        reps;
        t_place    place;
    } t_stim_row;

    localparam t_place NO_PLACE      = '0;
    localparam t_place OVERSIZE_SEEN = '{ST_OVERSIZE, 4'd0, 10'd0, 10'd0, 1'b0};
    localparam t_place PAGES_FULL    = '{ST_NO_PAGE, 4'd0, 10'd0, 10'd0, 1'b0};

    // resize rows carry the new page width and height in the rect fields
    t_stim_row stim_table [0:9] = '{
        '{ROW_KNOWN,   '{10'd0, 10'd0},       1, '{ST_PLACED, 4'd0, 10'd1, 10'd1, 1'b0}},
        '{ROW_KNOWN,   '{10'd1023, 10'd0},    1, OVERSIZE_SEEN},
        '{ROW_KNOWN,   '{10'd0, 10'd1023},    1, OVERSIZE_SEEN},
        '{ROW_KNOWN,   '{10'd1023, 10'd1023}, 1, OVERSIZE_SEEN},
        '{ROW_PREDICT, '{10'd1022, 10'd0},    1, NO_PLACE},
        '{ROW_PREDICT, '{10'd341, 10'd682},   1, NO_PLACE},
        '{ROW_RESIZE,  '{10'd3, 10'd3},       1, NO_PLACE},
        '{ROW_PREDICT, '{10'd0, 10'd0},      15, NO_PLACE},
        '{ROW_KNOWN,   '{10'd0, 10'd0},       1, PAGES_FULL},
        '{ROW_KNOWN,   '{10'd1, 10'd1},       1, PAGES_FULL}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    srp_stream_if #(.t_payload(t_rect))   rect_if ();
    srp_stream_if #(.t_payload(t_place))  place_if ();
    srp_stream_if #(.t_payload(t_cfg_wr)) cfg_if ();

    shelf_rect_packer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rect  (rect_if),
        .o_place (place_if),
        .i_cfg   (cfg_if)
    );

    // packer shadow state
    logic [CFG_W-1:0] cfg_width  = CFG_SIDE_RESET;
    logic [CFG_W-1:0] cfg_height = CFG_SIDE_RESET;
    int               pages_open = 1;
    logic [10:0]      shelf_x    [MAX_PAGES_DEF] = '{default: '0};
    logic [10:0]      shelf_y    [MAX_PAGES_DEF] = '{default: '0};
    logic [10:0]      shelf_tall [MAX_PAGES_DEF] = '{default: '0};

    t_place placements_due [$];
    int     mismatches     = 0;
    int     cycle_count    = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_request   = 0;
    int     hold_left      = 0;
    t_place got_place;
    t_place want_place;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int usable_side(input logic [CFG_W-1:0] v);
        return (int'(v) > MAX_PAGE_SIDE_DEF) ? MAX_PAGE_SIDE_DEF : int'(v);
    endfunction

    function automatic t_place pack_rect(input t_rect r);
        int     pw, ph, w, h, cx, cy, tall, p;
        t_place res;
        res = '0;
        pw  = int'(r.rect_width) + 2 * BORDER_DEF;
        ph  = int'(r.rect_height) + 2 * BORDER_DEF;
        w   = usable_side(cfg_width);
        h   = usable_side(cfg_height);
        if (pw > w || ph > h) begin
            res.status = ST_OVERSIZE;
            return res;
        end
        for (p = 0; p < pages_open; p++) begin
            cx   = int'(shelf_x[p]);
            cy   = int'(shelf_y[p]);
            tall = int'(shelf_tall[p]);
            if (cx + pw > w) begin
                cx   = 0;
                cy   = cy + tall;
                tall = 0;
            end
            if (cy + ph <= h) begin
                shelf_x[p]     = 11'(cx + pw);
                shelf_y[p]     = 11'(cy);
                shelf_tall[p]  = 11'((tall > ph) ? tall : ph);
                res.status     = ST_PLACED;
                res.page_index = PAGE_IDX_W'(p);
                res.pos_x      = POS_W'(cx + BORDER_DEF);
                res.pos_y      = POS_W'(cy + BORDER_DEF);
                return res;
            end
        end
        if (pages_open >= MAX_PAGES_DEF) begin
            res.status = ST_NO_PAGE;
            return res;
        end
        shelf_x[pages_open]    = 11'(pw);
        shelf_y[pages_open]    = '0;
        shelf_tall[pages_open] = 11'(ph);
        res.status      = ST_PLACED;
        res.page_index  = PAGE_IDX_W'(pages_open);
        res.pos_x       = POS_W'(BORDER_DEF);
        res.pos_y       = POS_W'(BORDER_DEF);
        res.opened_page = 1'b1;
        pages_open++;
        return res;
    endfunction

    // mostly small rectangles so pages last, some up to the page, a few full range
    function automatic t_rect pick_rect();
        int    wlim, hlim, sel;
        t_rect r;
        wlim = usable_side(cfg_width) - 2 * BORDER_DEF;
        hlim = usable_side(cfg_height) - 2 * BORDER_DEF;
        wlim = (wlim < 0) ? 0 : ((wlim > 1023) ? 1023 : wlim);
        hlim = (hlim < 0) ? 0 : ((hlim > 1023) ? 1023 : hlim);
        sel  = $urandom_range(0, 99);
        if (sel < 10) begin
            r.rect_width  = RECT_W'($urandom_range(0, 1023));
            r.rect_height = RECT_W'($urandom_range(0, 1023));
        end else if (sel < 75) begin
            r.rect_width  = RECT_W'($urandom_range(0, wlim / 8));
            r.rect_height = RECT_W'($urandom_range(0, hlim / 8));
        end else begin
            r.rect_width  = RECT_W'($urandom_range(0, wlim));
            r.rect_height = RECT_W'($urandom_range(0, hlim));
        end
        return r;
    endfunction

    task automatic offer_rect(input t_rect r, input bit known, input t_place want);
        t_place predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            rect_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        rect_if.valid <= 1'b1;
        rect_if.data  <= r;
        @(posedge i_clk);
        while (!rect_if.ready) @(posedge i_clk);
        predicted = pack_rect(r);
        placements_due = {placements_due, (known ? want : predicted)};
    endtask

    task automatic drain_placements();
        @(negedge i_clk);
        rect_if.valid <= 1'b0;
        while (placements_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{idx, value};
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            REG_PAGE_WIDTH:  cfg_width  = value;
            REG_PAGE_HEIGHT: cfg_height = value;
            default: ;
        endcase
    endtask

    task automatic set_page_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(REG_PAGE_WIDTH, w);
        write_reg(REG_PAGE_HEIGHT, h);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && place_if.valid && place_if.ready) begin
            got_place = place_if.data;
            if (placements_due.size() == 0) begin
                $display("%0t: unexpected placement, expected none, actual status %0d page %0d",
                         $time, got_place.status, got_place.page_index);
                mismatches++;
            end else begin
                want_place = placements_due.pop_front();
                if (got_place.status !== want_place.status)
                    flag_field("status", want_place.status, got_place.status);
                if (got_place.page_index !== want_place.page_index)
                    flag_field("page_index", want_place.page_index, got_place.page_index);
                if (got_place.pos_x !== want_place.pos_x)
                    flag_field("pos_x", want_place.pos_x, got_place.pos_x);
                if (got_place.pos_y !== want_place.pos_y)
                    flag_field("pos_y", want_place.pos_y, got_place.pos_y);
                if (got_place.opened_page !== want_place.opened_page)
                    flag_field("opened_page", want_place.opened_page, got_place.opened_page);
            end
        end
    end

    // result side: random stalls plus one long hold-off
    initial begin
        place_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                place_if.ready <= 1'b0;
            end else begin
                place_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        int          row_i, rep, phase, n;
        logic [10:0] new_w, new_h;
        rect_if.valid = 1'b0;
        rect_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        i_rst_n       = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (row_i = 0; row_i < $size(stim_table); row_i++) begin
            if (stim_table[row_i].kind == ROW_RESIZE) begin
                drain_placements();
                set_page_size(11'(stim_table[row_i].rect.rect_width),
                              11'(stim_table[row_i].rect.rect_height));
            end else begin
                for (rep = 0; rep < stim_table[row_i].reps; rep++)
                    offer_rect(stim_table[row_i].rect, stim_table[row_i].kind == ROW_KNOWN,
                               stim_table[row_i].place);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            drain_placements();
            case (phase)
                0: begin new_w = 11'd64;   new_h = 11'd48;   end
                1: begin new_w = 11'd3;    new_h = 11'd1024; end
                2: begin new_w = 11'd1024; new_h = 11'd3;    end
                3: begin new_w = 11'd500;  new_h = 11'd800;  end
                5: begin new_w = 11'd2047; new_h = 11'd2047; end
                6: begin
                    new_w = 11'($urandom_range(3, 1300));
                    new_h = 11'($urandom_range(3, 1300));
                end
                default: begin new_w = 11'd1024; new_h = 11'd1024; end
            endcase
            set_page_size(new_w, new_h);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                // long result hold-off while transfers keep coming
                if (phase == 4 && n == 20)
                    hold_request = 400;
                offer_rect(pick_rect(), 1'b0, NO_PLACE);
            end
        end

        drain_placements();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/srp_pkg.sv
hw/rtl/srp_stream_if.sv
hw/rtl/srp_page_store.sv
hw/rtl/shelf_rect_packer_unit.sv
dv/tb_shelf_rect_packer_unit.sv
